// ----- design/stop_and_wait_retry_sender_macros.svh -----
// Assertion macros for the stop-and-wait retry sender.
`ifndef STOP_AND_WAIT_RETRY_SENDER_MACROS_SVH
`define STOP_AND_WAIT_RETRY_SENDER_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge, ignored while in reset.
`define SWR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("swr: check failed");

// Checked on every rising edge, reset included.
`define SWR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("swr: check failed");

`else

`define SWR_ASSERT(label, prop)

`define SWR_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- design/swr_pkg.sv -----
// Types, codes and constants shared by the stop-and-wait retry sender.
`default_nettype none

package swr_pkg;

    localparam int unsigned MAX_PACKET_LEN = 256;
    localparam int unsigned NO_ACK_BIT     = 7;

    localparam logic [15:0] RETRY_INTERVAL_RESET = 16'd500;
    localparam logic [3:0]  MAX_RETRIES_RESET    = 4'd3;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_POLL = 2'd1,
        OP_ACK  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        POP_NONE   = 2'd0,
        POP_HIGH   = 2'd1,
        POP_NORMAL = 2'd2
    } pop_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RETRY_INTERVAL = 1'b0,
        CFG_MAX_RETRIES    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] retry_interval;
        logic [3:0]  max_retries;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic        high_ready;
        logic [7:0]  high_seq;
        logic [7:0]  high_command;
        logic [15:0] high_length;
        logic        normal_ready;
        logic [7:0]  normal_seq;
        logic [7:0]  normal_command;
        logic [15:0] normal_length;
        logic [7:0]  ack_seq;
        logic [7:0]  ack_command;
    } item_t;

    typedef struct packed {
        logic        waiting;
        logic [7:0]  seq;
        logic [7:0]  command;
        logic [8:0]  length;
        logic        from_normal;
        logic [3:0]  retries;
        logic [15:0] elapsed;
    } state_t;

    typedef struct packed {
        logic        resent;
        logic        gave_up;
        pop_t        popped;
        logic        sent_new;
        logic        dropped;
        logic [7:0]  seq;
        logic [7:0]  command;
        logic [8:0]  length;
        logic [3:0]  retries;
        logic        ack_matched;
        logic        awaiting;
    } result_t;

endpackage

`default_nettype wire

// ----- design/stop_and_wait_retry_sender.sv -----
// Top level of the stop-and-wait retry sender: request and result registers, state, config.
`default_nettype none

// Send-side control of a stop-and-wait link with a high and a normal queue. Each request
// (tick, poll, ack or no-op) yields exactly one result. One request is taken every cycle
// while the result does not stall: a request sits in the input register, the step logic
// works out the result and the next sender state from it combinationally, and both are
// registered together. The only loop is the sender state fed back into the step logic.
// A stalled result holds the input side back once the input register is also full. Config
// writes are taken at any time (cfg_ready is always high) and should be made only while
// the block is idle.
`include "stop_and_wait_retry_sender_macros.svh"

module stop_and_wait_retry_sender
#(
    parameter int unsigned MAX_PACKET_LEN = swr_pkg::MAX_PACKET_LEN
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [swr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [swr_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       operation,
    input  wire logic                             high_ready,
    input  wire logic [7:0]                       high_seq,
    input  wire logic [7:0]                       high_command,
    input  wire logic [15:0]                      high_length,
    input  wire logic                             normal_ready,
    input  wire logic [7:0]                       normal_seq,
    input  wire logic [7:0]                       normal_command,
    input  wire logic [15:0]                      normal_length,
    input  wire logic [7:0]                       ack_seq,
    input  wire logic [7:0]                       ack_command,

    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  resent,
    output logic                                  gave_up,
    output logic [1:0]                            popped_queue,
    output logic                                  sent_new,
    output logic                                  dropped_bad_length,
    output logic [7:0]                            send_seq,
    output logic [7:0]                            send_command,
    output logic [8:0]                            send_length,
    output logic [3:0]                            retries_done,
    output logic                                  ack_matched,
    output logic                                  awaiting_ack
);

    swr_pkg::cfg_t     cfg_reg;
    swr_pkg::item_t    item_reg;
    logic              item_valid_reg;
    swr_pkg::state_t   state_reg;
    swr_pkg::state_t   state_next;
    swr_pkg::result_t  result_reg;
    swr_pkg::result_t  result_next;
    logic              out_valid_reg;
    logic              advance;
    logic              accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_interval <= swr_pkg::RETRY_INTERVAL_RESET;
            cfg_reg.max_retries    <= swr_pkg::MAX_RETRIES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (swr_pkg::cfg_index_t'(cfg_index))
                swr_pkg::CFG_RETRY_INTERVAL: cfg_reg.retry_interval <= cfg_data[15:0];
                swr_pkg::CFG_MAX_RETRIES:    cfg_reg.max_retries    <= cfg_data[3:0];
            endcase
        end
    end

    // request moves on when the result register is free or being emptied
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op             <= swr_pkg::op_t'(operation);
            item_reg.high_ready     <= high_ready;
            item_reg.high_seq       <= high_seq;
            item_reg.high_command   <= high_command;
            item_reg.high_length    <= high_length;
            item_reg.normal_ready   <= normal_ready;
            item_reg.normal_seq     <= normal_seq;
            item_reg.normal_command <= normal_command;
            item_reg.normal_length  <= normal_length;
            item_reg.ack_seq        <= ack_seq;
            item_reg.ack_command    <= ack_command;
        end
    end

    swr_step
    #(
        .MAX_PACKET_LEN (MAX_PACKET_LEN)
    )
    u_step
    (
        .item    (item_reg),
        .st      (state_reg),
        .cfg     (cfg_reg),
        .st_next (state_next),
        .res     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign resent             = result_reg.resent;
    assign gave_up            = result_reg.gave_up;
    assign popped_queue       = result_reg.popped;
    assign sent_new           = result_reg.sent_new;
    assign dropped_bad_length = result_reg.dropped;
    assign send_seq           = result_reg.seq;
    assign send_command       = result_reg.command;
    assign send_length        = result_reg.length;
    assign retries_done       = result_reg.retries;
    assign ack_matched        = result_reg.ack_matched;
    assign awaiting_ack       = result_reg.awaiting;

    `SWR_ASSERT(a_resend_or_give_up, out_valid |-> !(resent && gave_up))
    `SWR_ASSERT(a_send_needs_pop,
        out_valid && (sent_new || dropped_bad_length) |->
            (popped_queue != swr_pkg::POP_NONE) && !(sent_new && dropped_bad_length))
    `SWR_ASSERT(a_idle_no_retries, !state_reg.waiting |-> state_reg.retries == 4'd0)
    `SWR_ASSERT_ALWAYS(a_stall_only_when_full, in_stall |-> item_valid_reg)

endmodule

`default_nettype wire

// ----- design/swr_step.sv -----
// One request's worth of sender logic: next state and result from state and request.
`default_nettype none

module swr_step
#(
    parameter int unsigned MAX_PACKET_LEN = swr_pkg::MAX_PACKET_LEN
)
(
    input  var swr_pkg::item_t   item,
    input  var swr_pkg::state_t  st,
    input  var swr_pkg::cfg_t    cfg,
    output swr_pkg::state_t      st_next,
    output swr_pkg::result_t     res
);

    logic        still_waiting;
    logic        pick_valid;
    logic        pick_normal;
    logic [7:0]  pick_seq;
    logic [7:0]  pick_command;
    logic [15:0] pick_length;
    logic        bad_length;

    // head selection: high queue wins
    always_comb
    begin
        pick_valid   = item.high_ready || item.normal_ready;
        pick_normal  = !item.high_ready;
        pick_seq     = item.high_ready ? item.high_seq : item.normal_seq;
        pick_command = item.high_ready ? item.high_command : item.normal_command;
        pick_length  = item.high_ready ? item.high_length : item.normal_length;
        bad_length   = (pick_length == 16'd0)
                    || (pick_length > 16'(MAX_PACKET_LEN));
    end

    always_comb
    begin
        st_next       = st;
        res           = '0;
        still_waiting = st.waiting;
        unique case (item.op)
            swr_pkg::OP_TICK:
            begin
                if (st.elapsed != '1)
                begin
                    st_next.elapsed = st.elapsed + 16'd1;
                end
            end
            swr_pkg::OP_POLL:
            begin
                if (st.waiting && (st.elapsed >= cfg.retry_interval))
                begin
                    if (st.retries < cfg.max_retries)
                    begin
                        st_next.retries = st.retries + 4'd1;
                        st_next.elapsed = '0;
                        res.resent      = 1'b1;
                        res.seq         = st.seq;
                        res.command     = st.command;
                        res.length      = st.length;
                    end
                    else
                    begin
                        still_waiting   = 1'b0;
                        st_next.waiting = 1'b0;
                        st_next.length  = '0;
                        st_next.retries = '0;
                        res.gave_up     = 1'b1;
                    end
                end
                if (!still_waiting && pick_valid)
                begin
                    res.popped = pick_normal ? swr_pkg::POP_NORMAL : swr_pkg::POP_HIGH;
                    if (bad_length)
                    begin
                        res.dropped = 1'b1;
                    end
                    else
                    begin
                        res.sent_new = 1'b1;
                        res.seq      = pick_seq;
                        res.command  = pick_command;
                        res.length   = pick_length[8:0];
                        if (pick_command[swr_pkg::NO_ACK_BIT])
                        begin
                            st_next.length = '0;
                        end
                        else
                        begin
                            st_next.waiting     = 1'b1;
                            st_next.seq         = pick_seq;
                            st_next.command     = pick_command;
                            st_next.length      = pick_length[8:0];
                            st_next.from_normal = pick_normal;
                            st_next.retries     = '0;
                            st_next.elapsed     = '0;
                        end
                    end
                end
            end
            swr_pkg::OP_ACK:
            begin
                if (st.waiting && (st.seq == item.ack_seq)
                    && (st.command == item.ack_command))
                begin
                    st_next.waiting     = 1'b0;
                    st_next.length      = '0;
                    st_next.retries     = '0;
                    st_next.elapsed     = '0;
                    st_next.from_normal = 1'b1;
                    res.ack_matched     = 1'b1;
                end
            end
            swr_pkg::OP_NOP:
            begin
            end
        endcase
        res.retries  = st_next.retries;
        res.awaiting = st_next.waiting;
    end

endmodule

`default_nettype wire

// ----- bench/stop_and_wait_retry_sender_tb.sv -----
// Self-checking bench for the stop-and-wait retry sender: shadow model, scoreboard, random requests.
module stop_and_wait_retry_sender_tb;
    import swr_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    // Shadow of the sender state; predicts one status per request and checks it on arrival.
    class sender_shadow;
        logic [15:0] interval    = RETRY_INTERVAL_RESET;
        logic [3:0]  retry_limit = MAX_RETRIES_RESET;
        state_t      st          = '0;
        result_t     due_status[$];
        int          errors      = 0;
        int          checked     = 0;
        int          requests    = 0;
        int          sends       = 0;
        int          resends     = 0;
        int          give_ups    = 0;
        int          drops       = 0;
        int          acks        = 0;

        function void set_register(cfg_index_t idx, logic [15:0] data);
            if (idx == CFG_RETRY_INTERVAL)
                interval = data;
            else
                retry_limit = data[3:0];
        endfunction

        function result_t next_status(item_t it);
            result_t     r;
            logic [7:0]  seq;
            logic [7:0]  cmd;
            logic [15:0] len;
            logic        from_normal;
            logic        popped;
            r = '0;
            case (it.op)
                OP_TICK:
                    if (st.elapsed != 16'hFFFF)
                        st.elapsed++;
                OP_POLL:
                begin
                    if (st.waiting && st.elapsed >= interval)
                    begin
                        if (st.retries < retry_limit)
                        begin
                            st.retries++;
                            st.elapsed = '0;
                            r.resent = 1'b1;
                            r.seq = st.seq;
                            r.command = st.command;
                            r.length = st.length;
                        end
                        else
                        begin
                            st.waiting = 1'b0;
                            st.length = '0;
                            st.retries = '0;
                            r.gave_up = 1'b1;
                        end
                    end
                    if (!st.waiting)
                    begin
                        popped = 1'b1;
                        seq = '0;
                        cmd = '0;
                        len = '0;
                        from_normal = 1'b0;
                        if (it.high_ready)
                        begin
                            seq = it.high_seq;
                            cmd = it.high_command;
                            len = it.high_length;
                            r.popped = POP_HIGH;
                        end
                        else if (it.normal_ready)
                        begin
                            seq = it.normal_seq;
                            cmd = it.normal_command;
                            len = it.normal_length;
                            from_normal = 1'b1;
                            r.popped = POP_NORMAL;
                        end
                        else
                            popped = 1'b0;
                        if (popped && (len == 0 || len > MAX_PACKET_LEN))
                            r.dropped = 1'b1;
                        else if (popped)
                        begin
                            r.sent_new = 1'b1;
                            r.seq = seq;
                            r.command = cmd;
                            r.length = len[8:0];
                            if (cmd[NO_ACK_BIT])
                                st.length = '0;
                            else
                            begin
                                st.waiting = 1'b1;
                                st.seq = seq;
                                st.command = cmd;
                                st.length = len[8:0];
                                st.from_normal = from_normal;
                                st.retries = '0;
                                st.elapsed = '0;
                            end
                        end
                    end
                end
                OP_ACK:
                    if (st.waiting && st.seq == it.ack_seq && st.command == it.ack_command)
                    begin
                        st.waiting = 1'b0;
                        st.length = '0;
                        st.retries = '0;
                        st.elapsed = '0;
                        st.from_normal = 1'b1;
                        r.ack_matched = 1'b1;
                    end
                default:
                    ;
            endcase
            r.retries = st.retries;
            r.awaiting = st.waiting;
            return r;
        endfunction

        function void take_request(item_t it);
            result_t r;
            r = next_status(it);
            requests++;
            sends += r.sent_new;
            resends += r.resent;
            give_ups += r.gave_up;
            drops += r.dropped;
            acks += r.ack_matched;
            due_status.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("tb: mismatch: %s", msg);
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("status %0d field %s got %0h want %0h", checked, name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (due_status.size() == 0)
            begin
                report("status arrived with no request outstanding");
                return;
            end
            want = due_status.pop_front();
            check_field("resent", got.resent, want.resent);
            check_field("gave_up", got.gave_up, want.gave_up);
            check_field("popped_queue", got.popped, want.popped);
            check_field("sent_new", got.sent_new, want.sent_new);
            check_field("dropped_bad_length", got.dropped, want.dropped);
            check_field("send_seq", got.seq, want.seq);
            check_field("send_command", got.command, want.command);
            check_field("send_length", got.length, want.length);
            check_field("retries_done", got.retries, want.retries);
            check_field("ack_matched", got.ack_matched, want.ack_matched);
            check_field("awaiting_ack", got.awaiting, want.awaiting);
            checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    item_t       req;
    logic        out_valid;
    logic        out_stall;
    logic        resent;
    logic        gave_up;
    logic [1:0]  popped_queue;
    logic        sent_new;
    logic        dropped_bad_length;
    logic [7:0]  send_seq;
    logic [7:0]  send_command;
    logic [8:0]  send_length;
    logic [3:0]  retries_done;
    logic        ack_matched;
    logic        awaiting_ack;
    result_t     seen;

    sender_shadow shadow;
    int          in_idle_pct;
    int          out_idle_pct;
    int          quiet_cycles = 0;

    assign seen = {resent, gave_up, popped_queue, sent_new, dropped_bad_length, send_seq,
                   send_command, send_length, retries_done, ack_matched, awaiting_ack};

    stop_and_wait_retry_sender uut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .operation          (req.op),
        .high_ready         (req.high_ready),
        .high_seq           (req.high_seq),
        .high_command       (req.high_command),
        .high_length        (req.high_length),
        .normal_ready       (req.normal_ready),
        .normal_seq         (req.normal_seq),
        .normal_command     (req.normal_command),
        .normal_length      (req.normal_length),
        .ack_seq            (req.ack_seq),
        .ack_command        (req.ack_command),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .resent             (resent),
        .gave_up            (gave_up),
        .popped_queue       (popped_queue),
        .sent_new           (sent_new),
        .dropped_bad_length (dropped_bad_length),
        .send_seq           (send_seq),
        .send_command       (send_command),
        .send_length        (send_length),
        .retries_done       (retries_done),
        .ack_matched        (ack_matched),
        .awaiting_ack       (awaiting_ack)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < out_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                shadow.set_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                shadow.take_request(req);
            if (out_valid && !out_stall)
                shadow.check_result(seen);
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: no handshake for %0d cycles", QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic item_t compose(op_t op, logic hr, logic [7:0] hs, logic [7:0] hc,
                                      logic [15:0] hl, logic nr, logic [7:0] ns,
                                      logic [7:0] nc, logic [15:0] nl, logic [7:0] as,
                                      logic [7:0] ac);
        item_t it;
        it.op = op;
        it.high_ready = hr;
        it.high_seq = hs;
        it.high_command = hc;
        it.high_length = hl;
        it.normal_ready = nr;
        it.normal_seq = ns;
        it.normal_command = nc;
        it.normal_length = nl;
        it.ack_seq = as;
        it.ack_command = ac;
        return it;
    endfunction

    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if ($urandom_range(3) != 0)
            c[NO_ACK_BIT] = 1'b0;
        return c;
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(11))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'(MAX_PACKET_LEN);
            3: return 16'(MAX_PACKET_LEN + 1);
            4: return 16'hFFFF;
            5: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(MAX_PACKET_LEN, 1));
        endcase
    endfunction

    // Acks mostly echo the held packet, sometimes with a bit flipped in the seq, the command or both.
    function automatic item_t random_request();
        item_t       it;
        int unsigned roll;
        roll = $urandom_range(99);
        it.op = roll < 38 ? OP_TICK : roll < 70 ? OP_POLL : roll < 94 ? OP_ACK : OP_NOP;
        it.high_ready = ($urandom_range(9) < 4);
        it.high_seq = 8'($urandom_range(255));
        it.high_command = pick_command();
        it.high_length = pick_length();
        it.normal_ready = ($urandom_range(9) < 6);
        it.normal_seq = 8'($urandom_range(255));
        it.normal_command = pick_command();
        it.normal_length = pick_length();
        it.ack_seq = 8'($urandom_range(255));
        it.ack_command = 8'($urandom_range(255));
        if (it.op == OP_ACK && shadow.st.waiting && $urandom_range(3) != 0)
        begin
            it.ack_seq = shadow.st.seq;
            it.ack_command = shadow.st.command;
            if ($urandom_range(5) == 0)
                it.ack_seq ^= 8'(1 << $urandom_range(7));
            if ($urandom_range(5) == 0)
                it.ack_command ^= 8'(1 << $urandom_range(7));
        end
        return it;
    endfunction

    // Entered and left at a falling edge; valid stays high after acceptance.
    task automatic send_request(item_t it);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (shadow.due_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic configure(logic [15:0] interval, logic [3:0] limit);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_RETRY_INTERVAL;
        cfg_data <= interval;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_index <= CFG_MAX_RETRIES;
        cfg_data <= {12'd0, limit};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_segment(logic [15:0] interval, logic [3:0] limit, int count);
        configure(interval, limit);
        repeat (count)
        begin
            send_request(random_request());
            if ($urandom_range(99) == 0)
                drain();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RETRY_INTERVAL;
        cfg_data = '0;
        in_valid = 1'b0;
        req = '0;
        out_stall = 1'b0;
        in_idle_pct = 25;
        out_idle_pct = 49;
        shadow = new();
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: drops, priority, no-ack send, idle, mismatched and matched acks
        send_request(compose(OP_NOP, 1, 8'hFF, 8'hFF, 16'hFFFF, 1, 8'hFF, 8'hFF, 16'hFFFF,
                             8'hFF, 8'hFF));
        send_request(compose(OP_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00));
        send_request(compose(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_POLL, 1, 8'h10, 8'h01, 16'd0, 1, 8'h20, 8'h02, 16'd8, 0, 0));
        send_request(compose(OP_POLL, 1, 8'h11, 8'h01, 16'd257, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_POLL, 0, 0, 0, 0, 1, 8'h21, 8'h02, 16'hFFFF, 0, 0));
        send_request(compose(OP_POLL, 1, 8'hFF, 8'h80, 16'd256, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_POLL, 0, 0, 0, 0, 1, 8'h00, 8'h7F, 16'd1, 0, 0));
        send_request(compose(OP_POLL, 1, 8'h11, 8'h22, 16'd5, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 8'h01, 8'h7F));
        send_request(compose(OP_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h7E));
        send_request(compose(OP_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h7F));

        // short interval: resend, then give up and send in the same poll
        configure(16'd2, 4'd1);
        send_request(compose(OP_POLL, 1, 8'hA5, 8'h5A, 16'd200, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(compose(OP_POLL, 0, 0, 0, 0, 1, 8'h3C, 8'hC3, 16'd64, 0, 0));
        send_request(compose(OP_POLL, 0, 0, 0, 0, 1, 8'h3D, 8'h43, 16'd256, 0, 0));
        send_request(compose(OP_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 8'h3D, 8'h43));

        run_segment(16'd1, 4'd0, 104);
        run_segment(16'd3, 4'd2, 104);
        in_idle_pct = 49;
        out_idle_pct = 25;
        run_segment(16'd0, 4'd15, 104);
        run_segment(16'd2, 4'd1, 104);
        in_idle_pct = 0;
        out_idle_pct = 0;
        run_segment(16'd4, 4'd15, 104);
        run_segment(16'd1, 4'd3, 104);

        drain();
        repeat (8)
            @(posedge clk);
        $display("tb: %0d requests, %0d statuses checked, %0d mismatches",
                 shadow.requests, shadow.checked, shadow.errors);
        $display("tb: %0d sent, %0d resent, %0d given up, %0d dropped, %0d acks matched",
                 shadow.sends, shadow.resends, shadow.give_ups, shadow.drops, shadow.acks);
        if (shadow.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+design
design/swr_pkg.sv
design/swr_step.sv
design/stop_and_wait_retry_sender.sv
bench/stop_and_wait_retry_sender_tb.sv
